@@ src/bmavg_pkg.sv @@
// Shared types, widths and constants for the moving-average barometric altimeter.
// No dependencies; every other file refers to it by scoped names.
package bmavg_pkg;

  localparam int SAMPLE_W = 17;
  localparam int ALT_W    = 24;
  localparam int DVD_W    = 33;
  localparam int RATIO_W  = 18;
  localparam int MANT_W   = 31;
  localparam int FRAC_W   = 16;
  localparam int EXPO_W   = 19;
  localparam int MUL_W    = 33;

  localparam logic [SAMPLE_W-1:0] GROUND_RESET = 17'd101325;
  localparam logic [RATIO_W-1:0]  RATIO_MAX    = 18'h3FFFF;
  localparam logic signed [MUL_W-1:0] EXP_COEF_Q24 = 33'sd3192704;
  localparam logic signed [MUL_W-1:0] ALT_SCALE_CM = 33'sd4433000;
  localparam logic signed [26:0] ALT_MIN = -27'sd1500000;
  localparam logic signed [26:0] ALT_MAX = 27'sd4433000;

  typedef struct packed {
    logic                    start;
    logic [DVD_W-1:0]        dividend;
    logic [SAMPLE_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [DVD_W-1:0]        quotient;
  } div_rsp_t;

  // 2^(2^-(idx+1)) in Q1.30, rounded
  function automatic logic [MANT_W-1:0] exp_tab(input logic [3:0] idx);
    logic [MANT_W-1:0] v;
    unique case (idx)
      4'd0:  v = 31'd1518500250;
      4'd1:  v = 31'd1276901417;
      4'd2:  v = 31'd1170923762;
      4'd3:  v = 31'd1121280436;
      4'd4:  v = 31'd1097253708;
      4'd5:  v = 31'd1085434106;
      4'd6:  v = 31'd1079572136;
      4'd7:  v = 31'd1076653033;
      4'd8:  v = 31'd1075196443;
      4'd9:  v = 31'd1074468888;
      4'd10: v = 31'd1074105294;
      4'd11: v = 31'd1073923544;
      4'd12: v = 31'd1073832680;
      4'd13: v = 31'd1073787251;
      4'd14: v = 31'd1073764537;
      4'd15: v = 31'd1073753181;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ src/bmavg_div.sv @@
// Restoring divider, one quotient bit per cycle, used for the pressure ratio step.
// Depends on bmavg_pkg.
module bmavg_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bmavg_pkg::div_req_t  req,
  output bmavg_pkg::div_rsp_t  rsp
);

  logic [5:0]                        cnt_r, cnt_nxt;
  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [bmavg_pkg::SAMPLE_W-1:0]    rem_r, rem_nxt;
  logic [bmavg_pkg::SAMPLE_W-1:0]    dsr_r, dsr_nxt;
  logic [bmavg_pkg::DVD_W-1:0]       dvd_r, dvd_nxt;
  logic [bmavg_pkg::DVD_W-1:0]       quo_r, quo_nxt;
  logic [bmavg_pkg::SAMPLE_W:0]      trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, dvd_r[bmavg_pkg::DVD_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      dvd_nxt  = req.dividend;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[bmavg_pkg::DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = bmavg_pkg::SAMPLE_W'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[bmavg_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[bmavg_pkg::SAMPLE_W-1:0];
        quo_nxt = {quo_r[bmavg_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(bmavg_pkg::DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ src/bmavg_ring.sv @@
// Sample ring memory with valid bits, ring position and running window sum.
// Depends on bmavg_pkg.
module bmavg_ring #(
  parameter int WINDOW = 10,
  parameter int SUM_W  = 21
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [bmavg_pkg::SAMPLE_W-1:0]   sample,
  output logic                             done,
  output logic [SUM_W-1:0]                 sum
);

  localparam int PW = $clog2(WINDOW);

  logic [bmavg_pkg::SAMPLE_W-1:0] mem [WINDOW];
  logic [WINDOW-1:0]              vld_r;
  logic [PW-1:0]                  pos_r;
  logic [SUM_W-1:0]               sum_r;
  logic [bmavg_pkg::SAMPLE_W-1:0] rd_r;
  logic                           rd_vld_r;
  logic [bmavg_pkg::SAMPLE_W-1:0] samp_r;
  logic                           upd_r;
  logic                           done_r;
  logic [bmavg_pkg::SAMPLE_W-1:0] old;

  assign old = rd_vld_r ? rd_r : '0;

  always_ff @(posedge clk) begin
    if (start) begin
      rd_r <= mem[pos_r];
    end
    if (upd_r) begin
      mem[pos_r] <= samp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      pos_r  <= '0;
      sum_r  <= '0;
      upd_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      upd_r  <= start;
      done_r <= upd_r;
      if (upd_r) begin
        vld_r[pos_r] <= 1'b1;
        sum_r <= sum_r - SUM_W'(old) + SUM_W'(samp_r);
        if (pos_r == PW'(WINDOW - 1)) begin
          pos_r <= '0;
        end else begin
          pos_r <= pos_r + PW'(1);
        end
      end
    end
    if (start) begin
      samp_r   <= sample;
      rd_vld_r <= vld_r[pos_r];
    end
  end

  assign done = done_r;
  assign sum  = sum_r;

endmodule

@@ src/bmavg_calc.sv @@
// Sequencer for mean, ratio, log2, power and altitude around one shared multiplier
// and the separate divider. Depends on bmavg_pkg.
module bmavg_calc #(
  parameter int WINDOW = 10,
  parameter int SUM_W  = 21
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [SUM_W-1:0]                      sum,
  input  logic [bmavg_pkg::SAMPLE_W-1:0]        ground,
  output bmavg_pkg::div_req_t                   div_req,
  input  bmavg_pkg::div_rsp_t                   div_rsp,
  output logic                                  done,
  output logic [bmavg_pkg::SAMPLE_W-1:0]        mean,
  output logic signed [bmavg_pkg::ALT_W-1:0]    alt
);

  // mean = (sum * MEAN_RCP) >> MEAN_SH, exact for every sum below 2^SUM_W
  localparam int     MEAN_SH  = SUM_W + $clog2(WINDOW);
  localparam longint MEAN_RCP = ((longint'(1) << MEAN_SH) + WINDOW - 1) / WINDOW;

  typedef enum logic [10:0] {
    C_IDLE  = 11'b00000000001,
    C_MEAN  = 11'b00000000010,
    C_CHK   = 11'b00000000100,
    C_WR    = 11'b00000001000,
    C_NORM  = 11'b00000010000,
    C_LOG   = 11'b00000100000,
    C_EXPO  = 11'b00001000000,
    C_EXP   = 11'b00010000000,
    C_SCALE = 11'b00100000000,
    C_ALT   = 11'b01000000000,
    C_FIN   = 11'b10000000000
  } calc_state_t;

  calc_state_t state_r, state_nxt;

  logic [bmavg_pkg::SAMPLE_W-1:0]     mean_r;
  logic [bmavg_pkg::RATIO_W-1:0]      ratio_r;
  logic [4:0]                         p_r;
  logic [bmavg_pkg::MANT_W-1:0]       m_r;
  logic [bmavg_pkg::FRAC_W-1:0]       frac_r;
  logic [3:0]                         cnt_r;
  logic signed [bmavg_pkg::EXPO_W-1:0] e_r;
  logic [bmavg_pkg::MANT_W-1:0]       r_r;
  logic [bmavg_pkg::RATIO_W-1:0]      power_r;
  logic signed [42:0]                 altp_r;
  logic signed [bmavg_pkg::ALT_W-1:0] alt_r;
  logic                               done_r;

  logic [bmavg_pkg::SAMPLE_W-1:0]     gnd;
  logic                               sat;
  logic [4:0]                         p_enc;
  logic signed [bmavg_pkg::MUL_W-1:0] mul_a, mul_b;
  logic signed [65:0]                 prod;
  logic [31:0]                        sq_top;
  logic [61:0]                        rnd;
  logic signed [5:0]                  pm16;
  logic signed [21:0]                 lg;
  logic signed [18:0]                 dpow;
  logic [2:0]                         neg_i;
  logic signed [42:0]                 adj;
  logic signed [26:0]                 q;

  assign gnd  = (ground == '0) ? bmavg_pkg::SAMPLE_W'(1) : ground;
  assign sat  = {2'b00, mean_r} >= {gnd, 2'b00};
  assign pm16 = $signed({1'b0, p_r}) - 6'sd16;
  assign lg   = $signed({pm16, frac_r});
  assign dpow = $signed(19'h10000) - $signed({1'b0, power_r});
  assign neg_i = 3'(-$signed(e_r[18:16]));

  always_comb begin
    p_enc = '0;
    for (int k = 0; k < bmavg_pkg::RATIO_W; k++) begin
      if (ratio_r[k]) begin
        p_enc = 5'(k);
      end
    end
  end

  always_comb begin
    unique case (state_r)
      C_MEAN: begin
        mul_a = bmavg_pkg::MUL_W'(sum);
        mul_b = bmavg_pkg::MUL_W'(MEAN_RCP);
      end
      C_LOG: begin
        mul_a = $signed({2'b00, m_r});
        mul_b = $signed({2'b00, m_r});
      end
      C_EXPO: begin
        mul_a = bmavg_pkg::MUL_W'(lg);
        mul_b = bmavg_pkg::EXP_COEF_Q24;
      end
      C_EXP: begin
        mul_a = $signed({2'b00, r_r});
        mul_b = $signed({2'b00, bmavg_pkg::exp_tab(cnt_r)});
      end
      C_ALT: begin
        mul_a = bmavg_pkg::MUL_W'(dpow);
        mul_b = bmavg_pkg::ALT_SCALE_CM;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign sq_top = prod[61:30];
  assign rnd    = prod[61:0] + 62'(64'd536870912);
  assign adj    = altp_r[42] ? altp_r + 43'sd65535 : altp_r;
  assign q      = adj[42:16];

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    if (state_r == C_CHK && !sat) begin
      div_req.start    = 1'b1;
      div_req.dividend = {mean_r, 16'h0000};
      div_req.divisor  = gnd;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE:  if (start) state_nxt = C_MEAN;
      C_MEAN:  state_nxt = C_CHK;
      C_CHK:   state_nxt = sat ? C_NORM : C_WR;
      C_WR: begin
        if (div_rsp.done) begin
          state_nxt = (div_rsp.quotient[bmavg_pkg::RATIO_W-1:0] == '0) ? C_ALT : C_NORM;
        end
      end
      C_NORM:  state_nxt = C_LOG;
      C_LOG:   if (cnt_r == 4'd15) state_nxt = C_EXPO;
      C_EXPO:  state_nxt = C_EXP;
      C_EXP:   if (cnt_r == 4'd15) state_nxt = C_SCALE;
      C_SCALE: state_nxt = C_ALT;
      C_ALT:   state_nxt = C_FIN;
      C_FIN:   state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == C_FIN);
    end
    unique case (state_r)
      C_MEAN: begin
        mean_r <= prod[MEAN_SH +: bmavg_pkg::SAMPLE_W];
      end
      C_CHK: begin
        if (sat) ratio_r <= bmavg_pkg::RATIO_MAX;
      end
      C_WR: begin
        if (div_rsp.done) begin
          ratio_r <= div_rsp.quotient[bmavg_pkg::RATIO_W-1:0];
          power_r <= '0;
        end
      end
      C_NORM: begin
        p_r    <= p_enc;
        m_r    <= bmavg_pkg::MANT_W'({13'h0, ratio_r} << (5'd30 - p_enc));
        frac_r <= '0;
        cnt_r  <= '0;
      end
      C_LOG: begin
        if (sq_top[31]) begin
          m_r <= sq_top[31:1];
          frac_r[4'd15 - cnt_r] <= 1'b1;
        end else begin
          m_r <= sq_top[30:0];
        end
        cnt_r <= cnt_r + 4'd1;
      end
      C_EXPO: begin
        e_r   <= prod[42:24];
        r_r   <= 31'h40000000;
        cnt_r <= '0;
      end
      C_EXP: begin
        if (e_r[4'd15 - cnt_r]) r_r <= rnd[60:30];
        cnt_r <= cnt_r + 4'd1;
      end
      C_SCALE: begin
        power_r <= bmavg_pkg::RATIO_W'(r_r >> (5'd14 + {2'b00, neg_i}));
      end
      C_ALT: begin
        altp_r <= prod[42:0];
      end
      C_FIN: begin
        if (q < bmavg_pkg::ALT_MIN) begin
          alt_r <= bmavg_pkg::ALT_W'(bmavg_pkg::ALT_MIN);
        end else if (q > bmavg_pkg::ALT_MAX) begin
          alt_r <= bmavg_pkg::ALT_W'(bmavg_pkg::ALT_MAX);
        end else begin
          alt_r <= q[bmavg_pkg::ALT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign done = done_r;
  assign mean = mean_r;
  assign alt  = alt_r;

endmodule

@@ src/moving_average_baro_altimeter_top.sv @@
// Top level of the moving-average barometric altimeter: stream ports, ground register,
// output register. Depends on bmavg_pkg, bmavg_ring, bmavg_div, bmavg_calc.
//
//  channel | dir | ports                         | payload
//  in      | in  | in_tvalid/in_tready/in_tdata  | pressure_pa
//  out     | out | out_tvalid/out_tready/out_tdata| mean_pressure_pa, altitude_cm
//  cfg     | in  | cfg_wr_en/cfg_wr_data         | ground_pressure_pa
//
// One request holds in_tready low through the ring update, a reciprocal multiply
// for the mean, the ratio divide (33 quotient bits), 16 squaring and 16 table steps
// on the shared multiplier, and setup, scaling, saturation and the output hand-off.
// A saturated ratio skips the divide, a zero ratio skips log and power. A full
// output register adds its stall on top.
// Synchronous active-low reset empties the ring and sets ground to 101325 Pa.
module moving_average_baro_altimeter_top #(
  parameter int WINDOW = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [16:0] pressure_pa
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [16:0] mean_pressure_pa, [40:17] altitude_cm
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data
);

  localparam int SUM_W = bmavg_pkg::SAMPLE_W + $clog2(WINDOW);

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_RING = 4'b0010,
    T_CALC = 4'b0100,
    T_OUT  = 4'b1000
  } top_state_t;

  top_state_t state_r, state_nxt;

  logic [bmavg_pkg::SAMPLE_W-1:0]     ground_r;
  logic                               out_vld_r;
  logic [47:0]                        out_data_r;
  logic                               in_acc;
  logic                               ring_done;
  logic [SUM_W-1:0]                   ring_sum;
  logic                               calc_done;
  logic [bmavg_pkg::SAMPLE_W-1:0]     calc_mean;
  logic signed [bmavg_pkg::ALT_W-1:0] calc_alt;
  logic                               load;
  bmavg_pkg::div_req_t                div_req;
  bmavg_pkg::div_rsp_t                div_rsp;

  assign in_tready = (state_r == T_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign load      = (state_r == T_OUT) && (!out_vld_r || out_tready);

  bmavg_ring #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .sample (in_tdata[bmavg_pkg::SAMPLE_W-1:0]),
    .done   (ring_done),
    .sum    (ring_sum)
  );

  bmavg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  bmavg_calc #(.WINDOW(WINDOW), .SUM_W(SUM_W)) u_calc (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ring_done),
    .sum     (ring_sum),
    .ground  (ground_r),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .done    (calc_done),
    .mean    (calc_mean),
    .alt     (calc_alt)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE:  if (in_acc) state_nxt = T_RING;
      T_RING:  if (ring_done) state_nxt = T_CALC;
      T_CALC:  if (calc_done) state_nxt = T_OUT;
      T_OUT:   if (load) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= T_IDLE;
      ground_r  <= bmavg_pkg::GROUND_RESET;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) ground_r <= cfg_wr_data;
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
    if (load) begin
      out_data_r <= {7'h00, calc_alt, calc_mean};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

@@ bench/moving_average_baro_altimeter_top_test.sv @@
// Self-checking bench for moving_average_baro_altimeter_top: pressure requests in,
// window mean and altitude out. Depends on the top module and bmavg_pkg.
`timescale 1ns / 100ps

module moving_average_baro_altimeter_top_test;

  localparam int WIN = 10;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [bmavg_pkg::SAMPLE_W-1:0] mean_pa;
    logic [bmavg_pkg::ALT_W-1:0]    alt_cm;
  } alt_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [16:0] cfg_wr_data = '0;

  // ring state of the predictor
  logic [bmavg_pkg::SAMPLE_W-1:0] ring_q [WIN];
  logic [31:0]                    sum_q;
  int                             pos_q;
  logic [bmavg_pkg::SAMPLE_W-1:0] ground_q;

  alt_result_t expected_q[$];
  int   fail_count = 0;
  int   sent_count = 0;
  int   got_count = 0;
  longint cycle_count = 0;
  bit   hold_off = 1'b0;
  int   stall_pct = 30;

  moving_average_baro_altimeter_top #(.WINDOW(WIN)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("moving_average_baro_altimeter_top_test: FAIL");
      $finish;
    end
  end

  function automatic longint log2_q16(input longint x);
    int p;
    longint m;
    longint frac;
    p = 0;
    frac = 0;
    for (int k = 0; k < 18; k++)
      if (x[k]) p = k;
    m = x << (30 - p);
    for (int k = 1; k <= 16; k++) begin
      m = (m * m) >>> 30;
      if (m >= (64'sd1 << 31)) begin
        m = m >>> 1;
        frac = frac | (64'sd1 << (16 - k));
      end
    end
    return longint'(p - 16) * 65536 + frac;
  endfunction

  function automatic longint exp2_q16(input longint e);
    longint i;
    longint f;
    longint sh;
    logic [63:0] r;
    i = (e >= 0) ? e / 65536 : -((-e + 65535) / 65536);
    f = e - i * 65536;
    r = 64'd1 << 30;
    for (int k = 1; k <= 16; k++)
      if (f[16-k]) r = (r * 64'(bmavg_pkg::exp_tab(4'(k - 1))) + (64'd1 << 29)) >> 30;
    sh = 14 - i;
    if (sh < 0) sh = 0;
    if (sh > 63) return 0;
    return longint'(r >> sh);
  endfunction

  function automatic longint altitude_for(input longint mean, input longint ground);
    longint ratio;
    longint pw;
    longint prod;
    longint e;
    longint alt;
    pw = 0;
    if (ground == 0) ground = 1;
    ratio = (mean << 16) / ground;
    if (ratio > 'h3FFFF) ratio = 'h3FFFF;
    if (ratio != 0) begin
      prod = log2_q16(ratio) * 3192704;
      e = (prod >= 0) ? prod / 16777216 : -((-prod + 16777215) / 16777216);
      pw = exp2_q16(e);
    end
    alt = (64'sd4433000 * (65536 - pw)) / 65536;
    if (alt < -1500000) alt = -1500000;
    if (alt > 4433000) alt = 4433000;
    return alt;
  endfunction

  function automatic alt_result_t predict_altitude(
    input logic [bmavg_pkg::SAMPLE_W-1:0] sample);
    alt_result_t res;
    longint mean;
    sum_q = sum_q - ring_q[pos_q] + sample;
    ring_q[pos_q] = sample;
    pos_q = (pos_q + 1) % WIN;
    mean = sum_q / WIN;
    res.mean_pa = mean[bmavg_pkg::SAMPLE_W-1:0];
    res.alt_cm = bmavg_pkg::ALT_W'(altitude_for(mean, ground_q));
    return res;
  endfunction

  task automatic send_pressure(input logic [bmavg_pkg::SAMPLE_W-1:0] sample);
    in_tdata <= {7'd0, sample};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(predict_altitude(sample));
    sent_count++;
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_burst(input logic [bmavg_pkg::SAMPLE_W-1:0] sample);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 40)) @(negedge clk);
    send_pressure(sample);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_ground(input logic [16:0] value);
    drain();
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ground_q = value;
  endtask

  // receiver
  always @(negedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    alt_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got_count++;
      if (expected_q.size() == 0) begin
        $error("unexpected result mean=%0d", out_tdata[16:0]);
        fail_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_tdata[16:0] !== exp_r.mean_pa) begin
          $error("mean_pressure_pa expected %0d got %0d", exp_r.mean_pa, out_tdata[16:0]);
          fail_count++;
        end
        if (out_tdata[40:17] !== exp_r.alt_cm) begin
          $error("altitude_cm expected %0d got %0d", $signed(exp_r.alt_cm),
                 $signed(out_tdata[40:17]));
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_pressure(17'd0);
    send_pressure(17'h1FFFF);
    send_pressure(17'd101325);
    for (int k = 0; k < 10; k++) send_pressure(17'h1FFFF);
    send_pressure(17'h15555);
    send_pressure(17'h0AAAA);
    write_ground(17'd0);
    send_pressure(17'd50000);
    write_ground(17'h1FFFF);
    for (int k = 0; k < 8; k++) send_pressure(17'd1);
    write_ground(17'd30000);
  endtask

  task automatic test_random_grounds();
    logic [16:0] grounds [5] = '{17'd30000, 17'd131071, 17'd101325, 17'd70000, 17'd0};
    for (int g = 0; g < 5; g++) begin
      write_ground(grounds[g]);
      stall_pct = (g % 2) ? 0 : 40;
      for (int n = 0; n < 240; n++) begin
        case ($urandom_range(0, 9))
          0: send_burst(17'($urandom));
          1: send_burst(17'd0);
          2: send_burst(17'h1FFFF);
          default: send_burst(17'($urandom_range(30000, 110000)));
        endcase
      end
    end
    write_ground(17'($urandom_range(30000, 131071)));
    for (int n = 0; n < 80; n++) send_burst(17'($urandom_range(80000, 105000)));
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (2000) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 20; n++) send_pressure(17'($urandom));
    join
    drain();
    for (int n = 0; n < 20; n++) send_pressure(17'($urandom_range(90000, 102000)));
  endtask

  initial begin
    for (int k = 0; k < WIN; k++) ring_q[k] = '0;
    sum_q = 0;
    pos_q = 0;
    ground_q = bmavg_pkg::GROUND_RESET;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_grounds();
    test_backpressure();
    drain();
    $display("Covered %0d requests, %0d results, ground extremes incl. zero,", sent_count,
             got_count);
    $display("saturation, zero mean and long output stalls.");
    if (fail_count == 0 && expected_q.size() == 0)
      $display("moving_average_baro_altimeter_top_test: PASS");
    else
      $display("moving_average_baro_altimeter_top_test: FAIL");
    $finish;
  end

endmodule

@@ moving_average_baro_altimeter_top.f @@
src/bmavg_pkg.sv
src/bmavg_div.sv
src/bmavg_ring.sv
src/bmavg_calc.sv
src/moving_average_baro_altimeter_top.sv
bench/moving_average_baro_altimeter_top_test.sv
